// ----- rtl/signed_int_to_decimal_ascii_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text unit
// Shared forms of clocked implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SID_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sid: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SID_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sid: next-cycle check failed");

`endif

// ----- rtl/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg
// Types and constants shared by the decimal text unit and its submodules.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int DATA_W     = 32;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(DATA_W);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int UPC_W      = 3;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef logic [UPC_W-1:0] upc_t;

    // Microcode addresses.
    localparam upc_t UPC_IDLE  = 3'd0;
    localparam upc_t UPC_SHIFT = 3'd1;
    localparam upc_t UPC_SIGN  = 3'd2;
    localparam upc_t UPC_SKIP  = 3'd3;
    localparam upc_t UPC_EMIT  = 3'd4;
    localparam upc_t UPC_DONE  = 3'd5;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_SHIFT,
        DP_SET_IDX,
        DP_SKIP,
        DP_NEXT_DIGIT
    } dp_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_MINUS,
        EMIT_DIGIT
    } emit_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_SHIFT_MORE,
        COND_LEAD_ZERO,
        COND_MORE_DIGITS
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        emit_t  emit;
        logic   wait_in;
        cond_t  cond;
        upc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic shift_more;
        logic lead_zero;
        logic more_digits;
        logic negative;
    } dp_flags_t;

    typedef struct packed {
        logic exec;
        logic in_ready;
        logic emit_valid;
    } seq_ctl_t;

endpackage

// ----- rtl/sid_rom.sv -----
// ----------------------------------------------------------------------------
// sid_rom
// Microcode store: one control word for each step of the conversion program.
// ----------------------------------------------------------------------------
module sid_rom (
    input  sid_pkg::upc_t       upc,
    output sid_pkg::ctrl_word_t cw
);
    import sid_pkg::*;

    always_comb
    begin
        cw = '{op: DP_NOP, emit: EMIT_NONE, wait_in: 1'b0,
               cond: COND_ALWAYS, target: UPC_IDLE};
        case (upc)
            UPC_IDLE:
                cw = '{op: DP_LOAD, emit: EMIT_NONE, wait_in: 1'b1,
                       cond: COND_NEVER, target: UPC_IDLE};
            UPC_SHIFT:
                cw = '{op: DP_SHIFT, emit: EMIT_NONE, wait_in: 1'b0,
                       cond: COND_SHIFT_MORE, target: UPC_SHIFT};
            UPC_SIGN:
                cw = '{op: DP_SET_IDX, emit: EMIT_MINUS, wait_in: 1'b0,
                       cond: COND_NEVER, target: UPC_IDLE};
            UPC_SKIP:
                cw = '{op: DP_SKIP, emit: EMIT_NONE, wait_in: 1'b0,
                       cond: COND_LEAD_ZERO, target: UPC_SKIP};
            UPC_EMIT:
                cw = '{op: DP_NEXT_DIGIT, emit: EMIT_DIGIT, wait_in: 1'b0,
                       cond: COND_MORE_DIGITS, target: UPC_EMIT};
            UPC_DONE:
                cw = '{op: DP_NOP, emit: EMIT_NONE, wait_in: 1'b0,
                       cond: COND_ALWAYS, target: UPC_IDLE};
            default:
                cw = '{op: DP_NOP, emit: EMIT_NONE, wait_in: 1'b0,
                       cond: COND_ALWAYS, target: UPC_IDLE};
        endcase
    end

endmodule

// ----- rtl/sid_seq.sv -----
// ----------------------------------------------------------------------------
// sid_seq
// Step counter with stall and conditional jump logic for the microprogram.
// ----------------------------------------------------------------------------
module sid_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  sid_pkg::ctrl_word_t cw,
    input  sid_pkg::dp_flags_t  flags,
    input  logic                in_valid,
    input  logic                slot_free,
    output sid_pkg::upc_t       upc,
    output sid_pkg::seq_ctl_t   ctl
);
    import sid_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic emit_active;
    logic stall;
    logic cond_true;

    always_comb
    begin
        case (cw.emit)
            EMIT_MINUS: emit_active = flags.negative;
            EMIT_DIGIT: emit_active = 1'b1;
            default:    emit_active = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cw.cond)
            COND_ALWAYS:      cond_true = 1'b1;
            COND_SHIFT_MORE:  cond_true = flags.shift_more;
            COND_LEAD_ZERO:   cond_true = flags.lead_zero;
            COND_MORE_DIGITS: cond_true = flags.more_digits;
            default:          cond_true = 1'b0;
        endcase
    end

    // A step holds while it waits for an input item or for room in the
    // output register.
    assign stall = (cw.wait_in && !in_valid) || (emit_active && !slot_free);

    always_comb
    begin
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (cond_true)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign upc            = upc_reg;
    assign ctl.exec       = !stall;
    assign ctl.in_ready   = cw.wait_in;
    assign ctl.emit_valid = !stall && emit_active;

endmodule

// ----- rtl/sid_datapath.sv -----
// ----------------------------------------------------------------------------
// sid_datapath
// Magnitude, shift-add-3 BCD register and digit pointer, driven by microcode.
// ----------------------------------------------------------------------------
module sid_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sid_pkg::DATA_W-1:0]   value,
    input  sid_pkg::dp_op_t              op,
    input  logic                         exec,
    output sid_pkg::dp_flags_t           flags,
    output logic [7:0]                   digit_char,
    output logic                         last_digit
);
    import sid_pkg::*;

    logic [DATA_W-1:0] bin_reg;
    logic [DATA_W-1:0] bin_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic [BCD_W-1:0]  bcd_adj;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              neg_reg;
    logic              neg_next;
    logic [3:0]        cur_digit;

    // Every BCD digit of five or more is raised by three before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        cur_digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (idx_reg == IDX_W'(i))
            begin
                cur_digit = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign flags.shift_more  = (cnt_reg != CNT_W'(DATA_W - 1));
    assign flags.more_digits = (idx_reg != '0);
    assign flags.lead_zero   = (idx_reg != '0) && (cur_digit == 4'd0);
    assign flags.negative    = neg_reg;
    assign digit_char        = CHAR_ZERO + {4'd0, cur_digit};
    assign last_digit        = (idx_reg == '0);

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        neg_next = neg_reg;
        if (exec)
        begin
            case (op)
                DP_LOAD:
                begin
                    // The magnitude is taken unsigned, so the most negative
                    // value converts without overflow.
                    neg_next = value[DATA_W-1];
                    bin_next = value[DATA_W-1] ? (~value + DATA_W'(1)) : value;
                    bcd_next = '0;
                    cnt_next = '0;
                end
                DP_SHIFT:
                begin
                    bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[DATA_W-1]};
                    bin_next = {bin_reg[DATA_W-2:0], 1'b0};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                DP_SET_IDX:
                begin
                    idx_next = IDX_W'(NUM_DIGITS - 1);
                end
                DP_SKIP:
                begin
                    if (flags.lead_zero)
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                DP_NEXT_DIGIT:
                begin
                    if (flags.more_digits)
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                default:
                begin
                    idx_next = idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

// ----- rtl/signed_int_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Renders a signed 32-bit integer as decimal ASCII text, one character at a time.
// ----------------------------------------------------------------------------
// Each item passes through these steps in order: acceptance, 32 shift-add-3
// steps, a sign step, a skip step per leading zero of the ten-digit BCD field
// plus one, a step per digit and a closing step; an output stall holds the
// current step. A new item is taken only once the last one is finished.
// Reset returns the step counter to the idle step.
module signed_int_to_decimal_ascii_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sid_pkg::DATA_W-1:0] value,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic [7:0]                 char_code,
    output logic                       last_char,
    output logic                       out_valid,
    input  logic                       out_ready
);
    import sid_pkg::*;

    upc_t       upc;
    ctrl_word_t cw;
    dp_flags_t  flags;
    seq_ctl_t   ctl;
    logic [7:0] digit_char;
    logic       last_digit;
    logic       slot_free;

    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic       last_reg;
    logic       last_next;
    logic       valid_reg;
    logic       valid_next;

    sid_rom u_rom (
        .upc (upc),
        .cw  (cw)
    );

    sid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .flags     (flags),
        .in_valid  (in_valid),
        .slot_free (slot_free),
        .upc       (upc),
        .ctl       (ctl)
    );

    sid_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .op         (cw.op),
        .exec       (ctl.exec),
        .flags      (flags),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        if (ctl.emit_valid)
        begin
            valid_next = 1'b1;
            if (cw.emit == EMIT_MINUS)
            begin
                char_next = CHAR_MINUS;
                last_next = 1'b0;
            end
            else
            begin
                char_next = digit_char;
                last_next = last_digit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign in_ready  = ctl.in_ready;
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign out_valid = valid_reg;

endmodule

// ----- rtl/sid_checker.sv -----
// ----------------------------------------------------------------------------
// sid_checker
// Port-level checks on the decimal text unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  char_code,
    input logic        last_char,
    input logic        out_valid,
    input logic        out_ready
);
    import sid_pkg::*;

    // A held character must not change under back-pressure.
    `SID_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(char_code) && $stable(last_char))

    // Only a minus sign or a decimal digit is ever produced.
    `SID_ASSERT_SAME(a_char_set, clk, rst_n, out_valid,
        char_code == CHAR_MINUS ||
        (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 8'd9))

    // A minus sign is never the final character of a number.
    `SID_ASSERT_SAME(a_minus_not_last, clk, rst_n, out_valid && char_code == CHAR_MINUS,
        !last_char)

    // Only one number is converted at a time.
    `SID_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // Once ready for a new item, anything still pending is the previous end.
    `SID_ASSERT_SAME(a_idle_after_last, clk, rst_n, in_ready && out_valid, last_char)

endmodule

bind signed_int_to_decimal_ascii_unit sid_checker u_sid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

// ----- tb/signed_int_to_decimal_ascii_unit_tb.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Feeds signed 32-bit integers to the decimal text unit and checks every
// emitted character and its end marker against a locally computed rendering.
// Both handshakes are throttled by random gaps and stalls.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sid_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic              clk;
    logic              rst_n;
    logic [DATA_W-1:0] value;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        char_code;
    logic              last_char;
    logic              out_valid;
    logic              out_ready;

    logic [DATA_W-1:0] pending_values[$];
    text_char_t        expected_text[$];
    int                mismatch_count;
    logic              in_taken;
    int                send_gap;
    int                stall_left;

    signed_int_to_decimal_ascii_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    always #2 clk = ~clk;

    // Appends the expected characters of one number, sign first.
    task automatic render_decimal(input logic [DATA_W-1:0] v);
        logic [31:0] mag;
        logic [7:0]  digit_chars[NUM_DIGITS];
        int          count;
        text_char_t  ch;
        begin
            mag   = v[DATA_W-1] ? (32'd0 - v) : v;
            count = 0;
            do
            begin
                digit_chars[count] = CHAR_ZERO + 8'(mag % 10);
                mag   = mag / 10;
                count = count + 1;
            end
            while (mag != 0 && count < NUM_DIGITS);
            if (v[DATA_W-1])
            begin
                ch.code = CHAR_MINUS;
                ch.last = 1'b0;
                expected_text.push_back(ch);
            end
            for (int k = count - 1; k >= 0; k--)
            begin
                ch.code = digit_chars[k];
                ch.last = (k == 0);
                expected_text.push_back(ch);
            end
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int next_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 4);
            else
                return $urandom_range(10, 50);
        end
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        int unsigned limit;
        int unsigned k;
        logic [DATA_W-1:0] v;
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    v = $urandom;
                8:
                begin
                    // Values at or just below a power of ten, of either sign.
                    k     = $urandom_range(0, 9);
                    limit = 1;
                    repeat (k) limit = limit * 10;
                    v = limit - $urandom_range(0, 1);
                    if ($urandom_range(0, 1))
                        v = -v;
                end
                9:
                begin
                    if ($urandom_range(0, 1))
                        v = 32'h8000_0000 + $urandom_range(0, 3);
                    else
                        v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                end
                default:
                begin
                    k     = $urandom_range(1, 9);
                    limit = 1;
                    repeat (k) limit = limit * 10;
                    v = $urandom_range(0, limit - 1);
                    if ($urandom_range(0, 1))
                        v = -v;
                end
            endcase
            return v;
        end
    endfunction

    // Handshake sampling, result checking and prediction on the rising edge.
    always @(posedge clk)
    begin
        text_char_t exp_ch;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                         $time, char_code, last_char);
                mismatch_count++;
            end
            else
            begin
                exp_ch = expected_text.pop_front();
                if (char_code !== exp_ch.code)
                begin
                    $display("%0t: char_code mismatch: expected %0d, actual %0d",
                             $time, exp_ch.code, char_code);
                    mismatch_count++;
                end
                if (last_char !== exp_ch.last)
                begin
                    $display("%0t: last_char mismatch: expected %0b, actual %0b",
                             $time, exp_ch.last, last_char);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            render_decimal(value);
    end

    // Input driver: holds the item until taken, then waits out a gap.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_taken)
        begin
            in_valid <= 1'b1;
        end
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_values.size() != 0)
        begin
            value    <= pending_values.pop_front();
            in_valid <= 1'b1;
            send_gap <= next_gap();
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Output stalls.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= next_gap();
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        value          = '0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        in_taken       = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        mismatch_count = 0;

        // Zero, single digits, the extremes, decade boundaries and mixed-digit patterns.
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'd99);
        pending_values.push_back(32'd100);
        pending_values.push_back(-32'sd100);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h8000_0001);
        pending_values.push_back(32'd999999999);
        pending_values.push_back(32'd1000000000);
        pending_values.push_back(-32'sd999999999);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'd1234567890);
        pending_values.push_back(-32'sd1234567890);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'd0);
        for (int i = 0; i < 260; i++)
            pending_values.push_back(random_value());

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        while (pending_values.size() != 0 || in_valid || expected_text.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("[signed_int_to_decimal_ascii_unit] OK");
        else
            $display("[signed_int_to_decimal_ascii_unit] ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("[signed_int_to_decimal_ascii_unit] ERROR");
        $finish;
    end

endmodule

// ----- signed_int_to_decimal_ascii_unit.f -----
+incdir+rtl
rtl/sid_pkg.sv
rtl/sid_rom.sv
rtl/sid_seq.sv
rtl/sid_datapath.sv
rtl/signed_int_to_decimal_ascii_unit.sv
rtl/sid_checker.sv
tb/signed_int_to_decimal_ascii_unit_tb.sv
